// ===== src/pict_pkg.sv =====
// Shared types, constants and the tracked PGN table for the instance conflict tracker.
// No dependencies; every other file but pict_ram imports this package.
package pict_pkg;

   localparam int TRACKED_PGNS = 10;
   localparam int SOURCE_SLOTS = 256;
   localparam int KNOWN_PGNS   = 10;
   localparam int PGN_COUNT    = (TRACKED_PGNS < KNOWN_PGNS) ? TRACKED_PGNS : KNOWN_PGNS;

   localparam int INST_VALS    = 256;
   localparam int GROUP_CAP    = 256;
   localparam int SLOT_DEPTH   = TRACKED_PGNS * SOURCE_SLOTS;
   localparam int GROUP_DEPTH  = TRACKED_PGNS * INST_VALS;
   localparam int CLR_DEPTH    = (SLOT_DEPTH > GROUP_DEPTH) ? SLOT_DEPTH : GROUP_DEPTH;

   localparam int PIDX_W   = (TRACKED_PGNS > 1) ? $clog2(TRACKED_PGNS) : 1;
   localparam int SLOT_AW  = $clog2(SLOT_DEPTH);
   localparam int GRP_AW   = $clog2(GROUP_DEPTH);
   localparam int CLR_AW   = $clog2(CLR_DEPTH);
   localparam int SRC_W    = 8;
   localparam int CNT_W    = 9;
   localparam int TOTAL_W  = 11;
   localparam int SLOT_W   = 9;

   typedef logic [17:0]         pgn_type;
   typedef logic [7:0]          byte_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [TOTAL_W-1:0]  total_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [PIDX_W-1:0]   pidx_type;
   typedef logic [SLOT_AW-1:0]  slot_addr_type;
   typedef logic [GRP_AW-1:0]   grp_addr_type;
   typedef logic [CLR_AW-1:0]   clr_addr_type;

   localparam byte_type NO_INST = 8'hFF;

   typedef enum logic {
      OP_TRACK = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_OLD,
      ST_DEC,
      ST_INC,
      ST_DONE
   } state_type;

   localparam pgn_type PGN_LIST [KNOWN_PGNS] = '{
      18'd127488, 18'd127489, 18'd127502, 18'd127505, 18'd127508,
      18'd127509, 18'd127513, 18'd130312, 18'd130314, 18'd130316
   };

   // set where the instance sits in data byte 1 rather than byte 0
   localparam logic USES_BYTE1 [KNOWN_PGNS] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
   };

   typedef struct packed {
      logic          hit;
      byte_type      inst;
      pidx_type      pidx;
      slot_addr_type slot_addr;
      grp_addr_type  grp_addr;
   } dec_type;

endpackage

// ===== src/pict_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on pict_pkg for field types.
interface pict_req_if;
   import pict_pkg::*;
   logic     valid;
   logic     ready;
   logic     opcode;
   pgn_type  pgn_number;
   byte_type source_addr;
   byte_type data_length;
   byte_type data_byte0;
   byte_type data_byte1;

   modport source (output valid, opcode, pgn_number, source_addr, data_length,
                   data_byte0, data_byte1, input ready);
   modport sink   (input valid, opcode, pgn_number, source_addr, data_length,
                   data_byte0, data_byte1, output ready);
endinterface

interface pict_rsp_if;
   import pict_pkg::*;
   logic      valid;
   logic      ready;
   logic      tracked;
   byte_type  instance_value;
   count_type group_sources;
   logic      group_conflict;
   total_type conflict_groups;

   modport source (output valid, tracked, instance_value, group_sources, group_conflict,
                   conflict_groups, input ready);
   modport sink   (input valid, tracked, instance_value, group_sources, group_conflict,
                   conflict_groups, output ready);
endinterface

// ===== src/pict_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
module pict_ram #(
   parameter int  WIDTH = 9,
   parameter int  DEPTH = 2560,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/pict_decode.sv =====
// Message classifier: PGN lookup, instance byte extraction and table addresses.
// Depends on pict_pkg.
module pict_decode (
   input  pict_pkg::pgn_type  pgn_number,
   input  pict_pkg::byte_type source_addr,
   input  pict_pkg::byte_type data_length,
   input  pict_pkg::byte_type data_byte0,
   input  pict_pkg::byte_type data_byte1,
   output pict_pkg::dec_type  dec
);
   import pict_pkg::*;

   logic     pgn_hit;
   logic     use_b1;
   pidx_type pidx;
   byte_type inst;
   logic     src_ok;

   always_comb begin
      pgn_hit = 1'b0;
      use_b1  = 1'b0;
      pidx    = '0;
      // list entries are distinct, so at most one matches
      for (int i = 0; i < PGN_COUNT; i++) begin
         if (pgn_number == PGN_LIST[i]) begin
            pgn_hit = 1'b1;
            use_b1  = USES_BYTE1[i];
            pidx    = PIDX_W'(i);
         end
      end

      inst = NO_INST;
      if (pgn_hit) begin
         if (use_b1) begin
            if (data_length >= 8'd2) begin
               inst = data_byte1;
            end
         end else if (data_length >= 8'd1) begin
            inst = data_byte0;
         end
      end

      src_ok = {1'b0, source_addr} < (SRC_W + 1)'(SOURCE_SLOTS);

      dec.hit       = pgn_hit && (inst != NO_INST) && src_ok;
      dec.inst      = inst;
      dec.pidx      = pidx;
      dec.slot_addr = SLOT_AW'(int'(pidx) * SOURCE_SLOTS + int'(source_addr));
      dec.grp_addr  = GRP_AW'(int'(pidx) * INST_VALS + int'(inst));
   end

endmodule

// ===== src/pgn_instance_conflict_tracker_core.sv =====
// PGN instance conflict tracker: top level with sequencer, slot and group memories.
// Depends on pict_pkg, pict_if, pict_ram and pict_decode.
//
// Usage:
//  req_ch carries one message or clear command per beat (valid/ready); rsp_ch returns
//  exactly one result beat per request, in order.
//  A tracked message reads the source's slot and its new group count in the accept
//  cycle, then reads the old group, decrements it, increments the new group and
//  rewrites the slot, passing through ST_OLD, ST_DEC, ST_INC and ST_DONE when the
//  instance changes; a new instance skips ST_DEC, a repeated one goes from ST_OLD
//  to ST_DONE, and an ignored message goes straight to ST_DONE. The next request
//  can be taken in the cycle after the result is moved to the output register; the
//  read-modify-write on the group memory, with its one read port, sets the beat cost.
//  The output register holds a result while rsp_ch is stalled; the next request is
//  still accepted and worked on, and waits in its final state until the register
//  frees up.
//  After reset, and after a clear command, both tables are swept to zero one entry
//  per cycle; req_ch.ready is low during the sweep. The result of a clear command is
//  delivered once the sweep ends.
module pgn_instance_conflict_tracker_core (
   input logic     clock,
   input logic     reset,
   pict_req_if.sink   req_ch,
   pict_rsp_if.source rsp_ch
);
   import pict_pkg::*;

   dec_type       dec;
   state_type     state_ff, state_in;

   byte_type      inst_ff, inst_in;
   pidx_type      pidx_ff, pidx_in;
   slot_addr_type slot_addr_ff, slot_addr_in;
   grp_addr_type  grp_addr_ff, grp_addr_in;
   grp_addr_type  oldg_ff, oldg_in;
   count_type     newcnt_ff, newcnt_in;
   total_type     total_ff, total_in;
   clr_addr_type  clr_ctr_ff, clr_ctr_in;
   logic          sweep_item_ff, sweep_item_in;

   logic          res_trk_ff, res_trk_in;
   byte_type      res_inst_ff, res_inst_in;
   count_type     res_cnt_ff, res_cnt_in;

   logic          out_valid_ff, out_valid_in;
   logic          out_trk_ff, out_trk_in;
   byte_type      out_inst_ff, out_inst_in;
   count_type     out_cnt_ff, out_cnt_in;
   logic          out_conf_ff, out_conf_in;
   total_type     out_total_ff, out_total_in;

   logic          slot_we;
   slot_addr_type slot_waddr;
   slot_type      slot_wdata;
   slot_type      slot_rdata;
   logic          grp_we;
   grp_addr_type  grp_waddr;
   count_type     grp_wdata;
   grp_addr_type  grp_raddr;
   count_type     grp_rdata;

   logic          accept;
   logic          is_clear;
   logic          same_inst;
   logic          clr_last;
   logic          out_load;
   grp_addr_type  old_grp_addr;
   count_type     cnt_inc;

   pict_decode u_decode (
      .pgn_number  (req_ch.pgn_number),
      .source_addr (req_ch.source_addr),
      .data_length (req_ch.data_length),
      .data_byte0  (req_ch.data_byte0),
      .data_byte1  (req_ch.data_byte1),
      .dec         (dec)
   );

   pict_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (dec.slot_addr),
      .rd_data (slot_rdata)
   );

   pict_ram #(.WIDTH(CNT_W), .DEPTH(GROUP_DEPTH)) u_group_ram (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (grp_waddr),
      .wr_data (grp_wdata),
      .rd_addr (grp_raddr),
      .rd_data (grp_rdata)
   );

   assign accept       = req_ch.valid && req_ch.ready;
   assign is_clear     = (req_ch.opcode == OP_CLEAR);
   assign same_inst    = slot_rdata[SLOT_W-1] && (slot_rdata[7:0] == inst_ff);
   assign clr_last     = (clr_ctr_ff == CLR_AW'(CLR_DEPTH - 1));
   assign out_load     = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ch.ready);
   assign old_grp_addr = GRP_AW'(int'(pidx_ff) * INST_VALS + int'(slot_rdata[7:0]));
   assign cnt_inc      = newcnt_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_clear) begin
                  state_in = ST_CLEAR;
               end else if (dec.hit) begin
                  state_in = ST_OLD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = sweep_item_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_OLD: begin
            if (same_inst) begin
               state_in = ST_DONE;
            end else if (slot_rdata[SLOT_W-1]) begin
               state_in = ST_DEC;
            end else begin
               state_in = ST_INC;
            end
         end
         ST_DEC:  state_in = ST_INC;
         ST_INC:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ch.ready  = (state_ff == ST_IDLE);
      inst_in       = inst_ff;
      pidx_in       = pidx_ff;
      slot_addr_in  = slot_addr_ff;
      grp_addr_in   = grp_addr_ff;
      oldg_in       = oldg_ff;
      newcnt_in     = newcnt_ff;
      total_in      = total_ff;
      clr_ctr_in    = clr_ctr_ff;
      sweep_item_in = sweep_item_ff;
      res_trk_in    = res_trk_ff;
      res_inst_in   = res_inst_ff;
      res_cnt_in    = res_cnt_ff;
      slot_we       = 1'b0;
      slot_waddr    = slot_addr_ff;
      slot_wdata    = {1'b1, inst_ff};
      grp_we        = 1'b0;
      grp_waddr     = grp_addr_ff;
      grp_wdata     = cnt_inc;
      grp_raddr     = dec.grp_addr;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               inst_in      = dec.inst;
               pidx_in      = dec.pidx;
               slot_addr_in = dec.slot_addr;
               grp_addr_in  = dec.grp_addr;
               res_cnt_in   = '0;
               if (is_clear) begin
                  res_trk_in    = 1'b0;
                  res_inst_in   = NO_INST;
                  total_in      = '0;
                  clr_ctr_in    = '0;
                  sweep_item_in = 1'b1;
               end else begin
                  res_trk_in  = dec.hit;
                  res_inst_in = dec.inst;
               end
            end
         end
         ST_CLEAR: begin
            slot_we    = {1'b0, clr_ctr_ff} < (CLR_AW + 1)'(SLOT_DEPTH);
            slot_waddr = clr_ctr_ff[SLOT_AW-1:0];
            slot_wdata = '0;
            grp_we     = {1'b0, clr_ctr_ff} < (CLR_AW + 1)'(GROUP_DEPTH);
            grp_waddr  = clr_ctr_ff[GRP_AW-1:0];
            grp_wdata  = '0;
            clr_ctr_in = clr_ctr_ff + 1'b1;
            if (clr_last) begin
               clr_ctr_in = '0;
            end
         end
         ST_OLD: begin
            // slot and new-group count arrive now; fetch the old group next
            grp_raddr = old_grp_addr;
            oldg_in   = old_grp_addr;
            newcnt_in = grp_rdata;
            if (same_inst) begin
               res_cnt_in = grp_rdata;
            end
         end
         ST_DEC: begin
            grp_waddr = oldg_ff;
            grp_wdata = grp_rdata - 1'b1;
            if (grp_rdata != '0) begin
               grp_we = 1'b1;
               if (grp_rdata == CNT_W'(2) && total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
            end
         end
         ST_INC: begin
            slot_we    = 1'b1;
            res_cnt_in = newcnt_ff;
            if (newcnt_ff < CNT_W'(GROUP_CAP)) begin
               grp_we     = 1'b1;
               res_cnt_in = cnt_inc;
               if (cnt_inc == CNT_W'(2)) begin
                  total_in = total_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            sweep_item_in = 1'b0;
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_trk_in   = out_trk_ff;
      out_inst_in  = out_inst_ff;
      out_cnt_in   = out_cnt_ff;
      out_conf_in  = out_conf_ff;
      out_total_in = out_total_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_trk_in   = res_trk_ff;
         out_inst_in  = res_inst_ff;
         out_cnt_in   = res_cnt_ff;
         out_conf_in  = res_cnt_ff >= CNT_W'(2);
         out_total_in = total_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         total_ff      <= '0;
         clr_ctr_ff    <= '0;
         sweep_item_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         clr_ctr_ff    <= clr_ctr_in;
         sweep_item_ff <= sweep_item_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inst_ff      <= inst_in;
      pidx_ff      <= pidx_in;
      slot_addr_ff <= slot_addr_in;
      grp_addr_ff  <= grp_addr_in;
      oldg_ff      <= oldg_in;
      newcnt_ff    <= newcnt_in;
      res_trk_ff   <= res_trk_in;
      res_inst_ff  <= res_inst_in;
      res_cnt_ff   <= res_cnt_in;
      out_trk_ff   <= out_trk_in;
      out_inst_ff  <= out_inst_in;
      out_cnt_ff   <= out_cnt_in;
      out_conf_ff  <= out_conf_in;
      out_total_ff <= out_total_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.tracked         = out_trk_ff;
   assign rsp_ch.instance_value  = out_inst_ff;
   assign rsp_ch.group_sources   = out_cnt_ff;
   assign rsp_ch.group_conflict  = out_conf_ff;
   assign rsp_ch.conflict_groups = out_total_ff;

   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      (accept && is_clear) |=> (total_ff == '0))
      else $error("conflict total not cleared by clear command");

   a_inc_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INC && grp_we) |-> (grp_wdata != '0))
      else $error("group increment wrote zero");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside final state");

   a_tracked_has_sources: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_trk_ff) |-> (out_cnt_ff != '0))
      else $error("tracked result with empty group");

endmodule
